// ----- rtl/rbh_pkg.sv -----
package rbh_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int GROUPS_W = 5;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_BINS_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_NO_BIN = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUPS = 2'd0,
    CFG_MIN    = 2'd1,
    CFG_MAX    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    cmd_t cmd;
    logic sample_ok;
    logic index_ok;
  } item_ctl_t;

endpackage

// ----- rtl/range_bin_histogram.sv -----
// Channel  Handshake            Payload
// input    in_valid/in_ready    cmd, sample_value, bin_index, lower_bound, upper_bound
// output   out_valid/out_ready  count_value, matched_bins, status
// config   cfg_we               cfg_index, cfg_data
//
// An item walks the row of bin cells, one cell per cycle, and its result is
// registered at the output once it leaves the last cell.
// A new item is taken only once the previous result has left the cell row, so
// items never overlap; the length of the cell row sets how often items are taken.
// Reset clears all limits and counts and loads the configuration registers with their defaults.
// A result that is not taken holds the row; the next item waits for it to leave.
module range_bin_histogram #(
  parameter int NUM_BINS    = rbh_pkg::NUM_BINS_DEF,
  parameter int SAMPLE_BITS = rbh_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = rbh_pkg::COUNT_BITS_DEF,
  localparam int IDX_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
  localparam int MATCH_W    = $clog2(NUM_BINS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rbh_pkg::CMD_W-1:0]         cmd,
  input  logic signed [SAMPLE_BITS-1:0]     sample_value,
  input  logic [IDX_W-1:0]                  bin_index,
  input  logic signed [SAMPLE_BITS-1:0]     lower_bound,
  input  logic signed [SAMPLE_BITS-1:0]     upper_bound,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COUNT_BITS-1:0]             count_value,
  output logic [MATCH_W-1:0]                matched_bins,
  output logic [rbh_pkg::STATUS_W-1:0]      status,
  input  logic                              cfg_we,
  input  logic [rbh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbh_pkg::CFG_W-1:0]         cfg_data
);
  import rbh_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

  logic [GROUPS_W-1:0]           groups_in_use;
  logic signed [CFG_W-1:0]       min_value;
  logic signed [CFG_W-1:0]       max_value;

  logic [GROUPS_W-1:0]           used;
  logic signed [CMP_W-1:0]       sample_ext;
  logic signed [CMP_W-1:0]       min_ext;
  logic signed [CMP_W-1:0]       max_ext;
  logic                          accept;
  logic                          idx_ok_now;
  logic                          sample_ok_now;
  cmd_t                          cmd_now;
  status_t                       status_now;

  item_ctl_t                     item_ctl;
  logic signed [SAMPLE_BITS-1:0] item_sample;
  logic signed [SAMPLE_BITS-1:0] item_lo;
  logic signed [SAMPLE_BITS-1:0] item_hi;
  logic [IDX_W-1:0]              item_idx;
  status_t                       item_status;

  state_t                        state;
  state_t                        state_next;
  logic                          start;
  logic                          load_out;
  logic                          out_valid_next;

  logic                          tok_valid [NUM_BINS+1];
  logic [MATCH_W-1:0]            tok_match [NUM_BINS+1];
  logic [COUNT_BITS-1:0]         tok_count [NUM_BINS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use <= GROUPS_W'(16);
      min_value     <= CFG_W'(16'h8000);
      max_value     <= CFG_W'(16'h7fff);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GROUPS: groups_in_use <= cfg_data[GROUPS_W-1:0];
        CFG_MIN:    min_value     <= cfg_data;
        CFG_MAX:    max_value     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign used = (int'(groups_in_use) > NUM_BINS) ? GROUPS_W'(NUM_BINS) : groups_in_use;

  assign sample_ext    = CMP_W'(sample_value);
  assign min_ext       = CMP_W'(min_value);
  assign max_ext       = CMP_W'(max_value);
  assign sample_ok_now = (sample_ext >= min_ext) && (sample_ext <= max_ext);
  assign idx_ok_now    = int'(bin_index) < int'(used);
  assign cmd_now       = cmd_t'(cmd);
  assign accept        = in_valid && in_ready;

  always_comb begin
    status_now = STATUS_OK;
    case (cmd_now)
      CMD_LOAD, CMD_READ: begin
        if (!idx_ok_now) begin
          status_now = STATUS_NO_BIN;
        end
      end
      CMD_SAMPLE: begin
        if (!sample_ok_now) begin
          status_now = STATUS_REJECT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_ctl.cmd       <= cmd_now;
      item_ctl.sample_ok <= sample_ok_now;
      item_ctl.index_ok  <= idx_ok_now;
      item_sample        <= sample_value;
      item_lo            <= lower_bound;
      item_hi            <= upper_bound;
      item_idx           <= bin_index;
      item_status        <= status_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      start     <= accept;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tok_valid[NUM_BINS]) begin
          if (!out_valid || out_ready) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      count_value  <= tok_count[NUM_BINS];
      matched_bins <= tok_match[NUM_BINS];
      status       <= item_status;
    end
  end

  assign tok_valid[0] = start;
  assign tok_match[0] = '0;
  assign tok_count[0] = '0;

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    rbh_cell #(
      .CELL_ID     (i),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .MATCH_W     (MATCH_W),
      .IDX_W       (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (item_ctl),
      .sample    (item_sample),
      .lo        (item_lo),
      .hi        (item_hi),
      .idx       (item_idx),
      .used      (used),
      .in_valid  (tok_valid[i]),
      .in_match  (tok_match[i]),
      .in_count  (tok_count[i]),
      .out_valid (tok_valid[i+1]),
      .out_match (tok_match[i+1]),
      .out_count (tok_count[i+1])
    );
  end

  a_tail_only_in_run: assert property (@(posedge clk) disable iff (rst)
    tok_valid[NUM_BINS] |-> state == ST_RUN)
    else $error("item left the cell row outside of a run");

  a_single_token: assert property (@(posedge clk) disable iff (rst)
    start |=> !start)
    else $error("two items entered the cell row back to back");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> (matched_bins == '0) && (count_value == '0))
    else $error("failed item carries a count or match");

  a_match_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(matched_bins) <= NUM_BINS)
    else $error("more matched bins than bins");

endmodule

// ----- rtl/rbh_cell.sv -----
module rbh_cell #(
  parameter int CELL_ID     = 0,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int MATCH_W     = 5,
  parameter int IDX_W       = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rbh_pkg::item_ctl_t                ctl,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic signed [SAMPLE_BITS-1:0]     lo,
  input  logic signed [SAMPLE_BITS-1:0]     hi,
  input  logic [IDX_W-1:0]                  idx,
  input  logic [rbh_pkg::GROUPS_W-1:0]      used,
  input  logic                              in_valid,
  input  logic [MATCH_W-1:0]                in_match,
  input  logic [COUNT_BITS-1:0]             in_count,
  output logic                              out_valid,
  output logic [MATCH_W-1:0]                out_match,
  output logic [COUNT_BITS-1:0]             out_count
);
  import rbh_pkg::*;

  logic signed [SAMPLE_BITS-1:0] lower;
  logic signed [SAMPLE_BITS-1:0] upper;
  logic [COUNT_BITS-1:0]         count;
  logic                          hit;
  logic                          in_use;
  logic                          here;
  logic                          bump;
  logic                          read_here;

  assign hit       = (sample >= lower) && (sample <= upper);
  assign in_use    = int'(used) > CELL_ID;
  assign here      = int'(idx) == CELL_ID;
  assign bump      = (ctl.cmd == CMD_SAMPLE) && ctl.sample_ok && in_use && hit;
  assign read_here = (ctl.cmd == CMD_READ) && ctl.index_ok && here;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower     <= '0;
      upper     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (in_valid) begin
        case (ctl.cmd)
          CMD_LOAD: begin
            if (here && ctl.index_ok) begin
              lower <= lo;
              upper <= hi;
            end
          end
          CMD_SAMPLE: begin
            if (bump && !(&count)) begin
              count <= count + COUNT_BITS'(1);
            end
          end
          CMD_CLEAR: begin
            count <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_match <= in_match + MATCH_W'(bump);
      out_count <= read_here ? count : in_count;
    end
  end

endmodule
